[hw/rtl/im2col_address_generator_top_assert.svh]
// Assertion macros shared by the im2col address generator RTL.
`ifndef IM2COL_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define IM2COL_ADDRESS_GENERATOR_TOP_ASSERT_SVH

// Whenever ante holds, cons holds in the same cycle.
`define IAG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in im2col address generator");

// Whenever ante holds, cons holds in the following cycle.
`define IAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in im2col address generator");

`endif

[hw/rtl/iag_pkg.sv]
// Package with the types and constants of the im2col address generator.
`default_nettype none
package iag_pkg;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_EMIT
   } state_type;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_IN_HEIGHT     = 3'd0,
      REG_IN_WIDTH      = 3'd1,
      REG_CHANNELS      = 3'd2,
      REG_KERNEL_HEIGHT = 3'd3,
      REG_KERNEL_WIDTH  = 3'd4,
      REG_CONV_STRIDE   = 3'd5,
      REG_PADDING       = 3'd6,
      REG_OUT_WIDTH     = 3'd7
   } reg_index_type;

   // Setup steps of the shared multiplier.
   typedef enum logic [3:0] {
      STEP_KSIZE    = 4'd0,
      STEP_YBASE    = 4'd1,
      STEP_XBASE    = 4'd2,
      STEP_ROWCOL   = 4'd3,
      STEP_CHK      = 4'd4,
      STEP_WINDOW   = 4'd5,
      STEP_CHANNEL  = 4'd6,
      STEP_CHH      = 4'd7,
      STEP_ROWBASE  = 4'd8
   } step_type;

   localparam int ADDR_W    = 5;
   localparam int IMG_W     = 30;
   localparam int COL_W     = 36;
   localparam int MUL_A_W   = 30;
   localparam int MUL_B_W   = 18;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int POS_W     = 15;   // signed window position, stride*index - padding
   localparam int ROWCOL_W  = 22;
   localparam int CHK_W     = 18;
   localparam int CHH_W     = 21;

endpackage
`default_nettype wire

[hw/rtl/im2col_address_generator_top.sv]
// Top level of the im2col / col2im address generator.
// An accepted item first runs its setup steps on one shared multiplier, then
// emits one word per cycle through the output register; results are never stalled.
// Busy stays high through setup and emission, and the next start is taken once idle.
// Reset is synchronous: control and configuration registers return to their reset
// values and the block goes idle; the datapath registers are not reset.
`default_nettype none
module im2col_address_generator_top #(
   parameter int MAX_KERNEL = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // command channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_command,
   input  wire logic [9:0]                  req_out_row,
   input  wire logic [9:0]                  req_out_col,
   input  wire logic [9:0]                  req_channel,
   // result channel
   output logic                             rsp_valid,
   output logic [iag_pkg::IMG_W-1:0]        rsp_image_address,
   output logic [iag_pkg::COL_W-1:0]        rsp_column_address,
   output logic                             rsp_outside,
   output logic                             rsp_last,
   // configuration port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [iag_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import iag_pkg::*;

   // Width of a clamped kernel dimension, of a kernel counter and of the kernel size.
   localparam int KVW = $clog2(MAX_KERNEL + 1);
   localparam int KCW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int KSW = 2 * KVW;

   // Configuration registers.
   logic [10:0]    in_height_ff, in_width_ff, channels_ff, out_width_ff;
   logic [3:0]     kernel_height_ff, kernel_width_ff, conv_stride_ff;
   logic [2:0]     padding_ff;

   // Sequencer state.
   state_type      state_ff, state_in;
   step_type       step_ff, step_in;

   // Latched item fields. The command does not change any address, so it is
   // only accepted and not stored.
   logic [9:0]     row_ff, row_in, col_ff, col_in, ch_ff, ch_in;

   // Setup results.
   logic [KSW-1:0]       ksize_ff, ksize_in;
   logic [POS_W-1:0]     ybase_ff, ybase_in, xbase_ff, xbase_in;
   logic [ROWCOL_W-1:0]  rowcol_ff, rowcol_in;
   logic [CHK_W-1:0]     chk_ff, chk_in;
   logic [CHH_W-1:0]     chh_ff, chh_in;

   // Walk through the kernel.
   logic [KCW-1:0]       kr_ff, kr_in, kc_ff, kc_in;
   logic [POS_W-1:0]     y_ff, y_in, x_ff, x_in;
   logic [IMG_W-1:0]     rowbase_ff, rowbase_in;
   logic [COL_W-1:0]     cursor_ff, cursor_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IMG_W-1:0]     rsp_image_ff, rsp_image_in;
   logic [COL_W-1:0]     rsp_column_ff, rsp_column_in;
   logic                 rsp_outside_ff, rsp_outside_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Shared multiplier.
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;

   logic [KVW-1:0]       kh_eff, kw_eff;
   logic                 accept, cfg_write;
   logic                 row_end, kernel_end, outside_now;
   logic [IMG_W-1:0]     image_now;

   assign pready    = 1'b1;
   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;
   assign busy      = (state_ff != ST_IDLE);
   assign mul_p     = mul_a * mul_b;

   // Kernel dimensions outside the supported range are clamped: zero acts as one,
   // anything above the largest kernel acts as the largest kernel.
   always_comb begin
      if (kernel_height_ff == 4'd0) begin
         kh_eff = KVW'(1);
      end else if (kernel_height_ff > 4'(MAX_KERNEL)) begin
         kh_eff = KVW'(MAX_KERNEL);
      end else begin
         kh_eff = kernel_height_ff[KVW-1:0];
      end
      if (kernel_width_ff == 4'd0) begin
         kw_eff = KVW'(1);
      end else if (kernel_width_ff > 4'(MAX_KERNEL)) begin
         kw_eff = KVW'(MAX_KERNEL);
      end else begin
         kw_eff = kernel_width_ff[KVW-1:0];
      end
   end

   // Register reads return the stored value zero extended.
   always_comb begin
      unique case (reg_index_type'(paddr[4:2]))
         REG_IN_HEIGHT:     prdata = 32'(in_height_ff);
         REG_IN_WIDTH:      prdata = 32'(in_width_ff);
         REG_CHANNELS:      prdata = 32'(channels_ff);
         REG_KERNEL_HEIGHT: prdata = 32'(kernel_height_ff);
         REG_KERNEL_WIDTH:  prdata = 32'(kernel_width_ff);
         REG_CONV_STRIDE:   prdata = 32'(conv_stride_ff);
         REG_PADDING:       prdata = 32'(padding_ff);
         REG_OUT_WIDTH:     prdata = 32'(out_width_ff);
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff     <= 11'd1;
         in_width_ff      <= 11'd1;
         channels_ff      <= 11'd1;
         kernel_height_ff <= 4'd1;
         kernel_width_ff  <= 4'd1;
         conv_stride_ff   <= 4'd1;
         padding_ff       <= 3'd0;
         out_width_ff     <= 11'd1;
      end else if (cfg_write) begin
         unique case (reg_index_type'(paddr[4:2]))
            REG_IN_HEIGHT:     in_height_ff     <= pwdata[10:0];
            REG_IN_WIDTH:      in_width_ff      <= pwdata[10:0];
            REG_CHANNELS:      channels_ff      <= pwdata[10:0];
            REG_KERNEL_HEIGHT: kernel_height_ff <= pwdata[3:0];
            REG_KERNEL_WIDTH:  kernel_width_ff  <= pwdata[3:0];
            REG_CONV_STRIDE:   conv_stride_ff   <= pwdata[3:0];
            REG_PADDING:       padding_ff       <= pwdata[2:0];
            REG_OUT_WIDTH:     out_width_ff     <= pwdata[10:0];
            default:           ;
         endcase
      end
   end

   // Position test and image address of the kernel position being emitted.
   // The row base already holds (channel*H + y)*W modulo the field width, so adding
   // the signed column gives the element offset; wrapping is harmless because the
   // address is only used when the position lies inside the image.
   assign outside_now = y_ff[POS_W-1] || x_ff[POS_W-1]
                     || ($signed(y_ff) >= $signed(POS_W'(in_height_ff)))
                     || ($signed(x_ff) >= $signed(POS_W'(in_width_ff)));
   assign image_now   = rowbase_ff + {{(IMG_W-POS_W){x_ff[POS_W-1]}}, x_ff};
   assign row_end     = (KVW'(kc_ff) == kw_eff - KVW'(1));
   assign kernel_end  = row_end && (KVW'(kr_ff) == kh_eff - KVW'(1));

   // Sequencer: nine setup steps on the shared multiplier, then one position per cycle.
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      ch_in          = ch_ff;
      ksize_in       = ksize_ff;
      ybase_in       = ybase_ff;
      xbase_in       = xbase_ff;
      rowcol_in      = rowcol_ff;
      chk_in         = chk_ff;
      chh_in         = chh_ff;
      kr_in          = kr_ff;
      kc_in          = kc_ff;
      y_in           = y_ff;
      x_in           = x_ff;
      rowbase_in     = rowbase_ff;
      cursor_in      = cursor_ff;
      rsp_valid_in   = 1'b0;
      rsp_image_in   = rsp_image_ff;
      rsp_column_in  = rsp_column_ff;
      rsp_outside_in = rsp_outside_ff;
      rsp_last_in    = rsp_last_ff;
      mul_a          = '0;
      mul_b          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in   = req_out_row;
               col_in   = req_out_col;
               ch_in    = req_channel;
               step_in  = STEP_KSIZE;
               state_in = ST_SETUP;
            end
         end

         ST_SETUP: begin
            step_in = step_type'(step_ff + 4'd1);
            unique case (step_ff)
               STEP_KSIZE: begin
                  mul_a    = MUL_A_W'(kh_eff);
                  mul_b    = MUL_B_W'(kw_eff);
                  ksize_in = mul_p[KSW-1:0];
               end
               STEP_YBASE: begin
                  mul_a    = MUL_A_W'(row_ff);
                  mul_b    = MUL_B_W'(conv_stride_ff);
                  ybase_in = mul_p[POS_W-1:0] - POS_W'(padding_ff);
               end
               STEP_XBASE: begin
                  mul_a    = MUL_A_W'(col_ff);
                  mul_b    = MUL_B_W'(conv_stride_ff);
                  xbase_in = mul_p[POS_W-1:0] - POS_W'(padding_ff);
               end
               STEP_ROWCOL: begin
                  mul_a     = MUL_A_W'(row_ff);
                  mul_b     = MUL_B_W'(out_width_ff);
                  rowcol_in = mul_p[ROWCOL_W-1:0] + ROWCOL_W'(col_ff);
               end
               STEP_CHK: begin
                  mul_a  = MUL_A_W'(channels_ff);
                  mul_b  = MUL_B_W'(ksize_ff);
                  chk_in = mul_p[CHK_W-1:0];
               end
               STEP_WINDOW: begin
                  mul_a     = MUL_A_W'(rowcol_ff);
                  mul_b     = MUL_B_W'(chk_ff);
                  cursor_in = mul_p[COL_W-1:0];
               end
               STEP_CHANNEL: begin
                  mul_a     = MUL_A_W'(ch_ff);
                  mul_b     = MUL_B_W'(ksize_ff);
                  cursor_in = cursor_ff + mul_p[COL_W-1:0];
               end
               STEP_CHH: begin
                  mul_a  = MUL_A_W'(ch_ff);
                  mul_b  = MUL_B_W'(in_height_ff);
                  chh_in = mul_p[CHH_W-1:0];
               end
               STEP_ROWBASE: begin
                  mul_a      = MUL_A_W'(chh_ff)
                             + {{(MUL_A_W-POS_W){ybase_ff[POS_W-1]}}, ybase_ff};
                  mul_b      = MUL_B_W'(in_width_ff);
                  rowbase_in = mul_p[IMG_W-1:0];
                  y_in       = ybase_ff;
                  x_in       = xbase_ff;
                  kr_in      = '0;
                  kc_in      = '0;
                  step_in    = STEP_KSIZE;
                  state_in   = ST_EMIT;
               end
               default: begin
                  step_in  = STEP_KSIZE;
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_EMIT: begin
            rsp_valid_in   = 1'b1;
            rsp_image_in   = outside_now ? '0 : image_now;
            rsp_column_in  = cursor_ff;
            rsp_outside_in = outside_now;
            rsp_last_in    = kernel_end;
            cursor_in      = cursor_ff + COL_W'(1);
            if (row_end) begin
               kc_in      = '0;
               kr_in      = kr_ff + KCW'(1);
               x_in       = xbase_ff;
               y_in       = y_ff + POS_W'(1);
               rowbase_in = rowbase_ff + IMG_W'(in_width_ff);
            end else begin
               kc_in = kc_ff + KCW'(1);
               x_in  = x_ff + POS_W'(1);
            end
            if (kernel_end) begin
               kr_in    = '0;
               kc_in    = '0;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_KSIZE;
         kr_ff        <= '0;
         kc_ff        <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         kr_ff        <= kr_in;
         kc_ff        <= kc_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      col_ff         <= col_in;
      ch_ff          <= ch_in;
      ksize_ff       <= ksize_in;
      ybase_ff       <= ybase_in;
      xbase_ff       <= xbase_in;
      rowcol_ff      <= rowcol_in;
      chk_ff         <= chk_in;
      chh_ff         <= chh_in;
      y_ff           <= y_in;
      x_ff           <= x_in;
      rowbase_ff     <= rowbase_in;
      rsp_image_ff   <= rsp_image_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_outside_ff <= rsp_outside_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_image_address  = rsp_image_ff;
   assign rsp_column_address = rsp_column_ff;
   assign rsp_outside        = rsp_outside_ff;
   assign rsp_last           = rsp_last_ff;

   // A word tagged last always leaves the sequencer idle.
   `include "im2col_address_generator_top_assert.svh"
   `IAG_ASSERT_SAME(a_last_idle, clock, reset, rsp_valid_ff && rsp_last_ff, state_ff == ST_IDLE)
   `IAG_ASSERT_NEXT(a_accept_setup, clock, reset, accept, (state_ff == ST_SETUP) && !rsp_valid_ff)
   `IAG_ASSERT_SAME(a_pad_zero, clock, reset, rsp_valid_ff && rsp_outside_ff, rsp_image_ff == '0)
   `IAG_ASSERT_NEXT(a_word_from_emit, clock, reset, state_ff != ST_EMIT, !rsp_valid_ff)

endmodule
`default_nettype wire
